>>> hw/rtl/tam_pkg.sv
package tam_pkg;

  localparam int AXES       = 6;
  localparam int THRUSTERS  = 8;
  localparam int AXIS_W     = 8;
  localparam int OFF_W      = 9;
  localparam int MAG_W      = 8;
  localparam int SQ_W       = 16;
  localparam int GAIN_W     = 8;
  localparam int SHAPE_W    = 16;
  localparam int QUOT_W     = 13;
  localparam int SUM_W      = 19;
  localparam int THRUST_W   = 18;
  localparam int COEF_W     = 2;
  localparam int ROW_W      = AXES * COEF_W;
  localparam int MIX_W      = 48;
  localparam int ROWS_REG   = MIX_W / ROW_W;

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam int RECIP_W    = 17;
  localparam logic [RECIP_W-1:0] RECIP_10 = 17'd52429;
  localparam int RECIP_SH   = 19;
  localparam int PROD_W     = SQ_W + RECIP_W;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 19'sd131071;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -19'sd131072;

  localparam logic [COEF_W-1:0] COEF_POS = 2'b01;
  localparam logic [COEF_W-1:0] COEF_NEG = 2'b11;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_CURVE_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIX_LOW    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIX_HIGH   = 2'd2;

  localparam logic            CURVE_MODE_RST = 1'b1;
  localparam logic [MIX_W-1:0] MIX_LOW_RST   = 48'h04F0C70CD045;
  localparam logic [MIX_W-1:0] MIX_HIGH_RST  = 48'h010010010010;

  typedef logic signed [SHAPE_W-1:0]  shape_t;
  typedef logic signed [THRUST_W-1:0] thrust_t;
  typedef logic [ROW_W-1:0]           coef_row_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic curve_mode;
  } pipe_ctrl_t;

endpackage

>>> hw/rtl/tam_cmd_if.sv
interface tam_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tam_pkg::AXIS_W-1:0]  axis_x;
  logic [tam_pkg::AXIS_W-1:0]  axis_y;
  logic [tam_pkg::AXIS_W-1:0]  axis_z;
  logic [tam_pkg::AXIS_W-1:0]  axis_yaw;
  logic [tam_pkg::AXIS_W-1:0]  axis_roll;
  logic [tam_pkg::AXIS_W-1:0]  axis_pitch;

  modport source (
    output valid, axis_x, axis_y, axis_z, axis_yaw, axis_roll, axis_pitch,
    input  ready
  );
  modport sink (
    input  valid, axis_x, axis_y, axis_z, axis_yaw, axis_roll, axis_pitch,
    output ready
  );
endinterface

>>> hw/rtl/tam_thrust_if.sv
interface tam_thrust_if;
  logic                                valid;
  logic                                ready;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_1;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_2;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_3;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_4;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_5;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_6;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_7;
  logic signed [tam_pkg::THRUST_W-1:0] thrust_8;

  modport source (
    output valid, thrust_1, thrust_2, thrust_3, thrust_4,
           thrust_5, thrust_6, thrust_7, thrust_8,
    input  ready
  );
  modport sink (
    input  valid, thrust_1, thrust_2, thrust_3, thrust_4,
           thrust_5, thrust_6, thrust_7, thrust_8,
    output ready
  );
endinterface

>>> hw/rtl/tam_axis_shaper.sv
// One axis lane: center, then square and divide by ten via reciprocal, or scale by the linear gain.
module tam_axis_shaper #(
  parameter int INPUT_MID   = 125,
  parameter int LINEAR_GAIN = 100
) (
  input  logic                       clk,
  input  tam_pkg::pipe_ctrl_t        ctrl,
  input  logic [tam_pkg::AXIS_W-1:0] raw,
  output tam_pkg::shape_t            shaped
);

  localparam logic signed [tam_pkg::OFF_W-1:0]  MID_S  = tam_pkg::OFF_W'(INPUT_MID);
  localparam logic signed [tam_pkg::GAIN_W-1:0] GAIN_S = tam_pkg::GAIN_W'(LINEAR_GAIN);
  localparam int LIN_FULL_W = tam_pkg::OFF_W + tam_pkg::GAIN_W;

  logic signed [tam_pkg::OFF_W-1:0]  off;
  logic signed [tam_pkg::OFF_W-1:0]  off_abs;
  logic [tam_pkg::MAG_W-1:0]         mag;
  logic signed [LIN_FULL_W-1:0]      lin_full;
  logic [tam_pkg::SQ_W-1:0]          sq;
  tam_pkg::shape_t                   lin;
  logic                              neg;
  logic [tam_pkg::PROD_W-1:0]        prod;
  logic [tam_pkg::QUOT_W-1:0]        quot;
  tam_pkg::shape_t                   quot_s;
  tam_pkg::shape_t                   shaped_next;

  // with INPUT_MID = 125, offset stays within -125..130, so 9 bits never wrap
  assign off      = $signed({1'b0, raw}) - MID_S;
  assign off_abs  = off[tam_pkg::OFF_W-1] ? -off : off;
  assign mag      = off_abs[tam_pkg::MAG_W-1:0];
  assign lin_full = off * GAIN_S;

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      sq  <= mag * mag;
      lin <= lin_full[tam_pkg::SHAPE_W-1:0];
      neg <= off[tam_pkg::OFF_W-1];
    end
  end

  assign prod   = sq * tam_pkg::RECIP_10;
  assign quot   = prod[tam_pkg::RECIP_SH +: tam_pkg::QUOT_W];
  assign quot_s = $signed({{(tam_pkg::SHAPE_W - tam_pkg::QUOT_W){1'b0}}, quot});

  always_comb begin
    if (ctrl.curve_mode) begin
      shaped_next = neg ? -quot_s : quot_s;
    end else begin
      shaped_next = lin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      shaped <= shaped_next;
    end
  end

endmodule

>>> hw/rtl/tam_thrust_mix.sv
// One thruster lane: signed sum of the six shaped axes, then clamp.
module tam_thrust_mix (
  input  logic                  clk,
  input  tam_pkg::pipe_ctrl_t   ctrl,
  input  tam_pkg::coef_row_t    coef,
  input  tam_pkg::shape_t       shaped [tam_pkg::AXES],
  output tam_pkg::thrust_t      thrust
);

  logic signed [tam_pkg::SUM_W-1:0] sum;
  logic signed [tam_pkg::SUM_W-1:0] term;
  logic signed [tam_pkg::SUM_W-1:0] clamped;

  always_comb begin
    sum  = '0;
    term = '0;
    for (int a = 0; a < tam_pkg::AXES; a++) begin
      term = tam_pkg::SUM_W'(shaped[a]);
      case (coef[a*tam_pkg::COEF_W +: tam_pkg::COEF_W])
        tam_pkg::COEF_POS: sum = sum + term;
        tam_pkg::COEF_NEG: sum = sum - term;
        default:           sum = sum;   // zero and the reserved code
      endcase
    end
    if (sum > tam_pkg::SAT_MAX) begin
      clamped = tam_pkg::SAT_MAX;
    end else if (sum < tam_pkg::SAT_MIN) begin
      clamped = tam_pkg::SAT_MIN;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      thrust <= clamped[tam_pkg::THRUST_W-1:0];
    end
  end

endmodule

>>> hw/rtl/thruster_axis_mixer.sv
// Pipeline: request accept to result valid runs through three pipe stages
// (center/square, divide-by-ten multiply, lane sum and clamp).
// Throughput: one request per cycle; a stalled result holds the pipe in place.
// Reset: synchronous, clears pipe valids and loads curve_mode = quadratic
// and the default mixing rows. No clearing pass.
module thruster_axis_mixer #(
  parameter int INPUT_MID   = 125,
  parameter int LINEAR_GAIN = 100
) (
  input  logic                               clk,
  input  logic                               rst,
  tam_cmd_if.sink                            cmd,
  tam_thrust_if.source                       demand,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tam_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tam_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tam_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic                         curve_mode;
  logic [tam_pkg::MIX_W-1:0]    mix_low;
  logic [tam_pkg::MIX_W-1:0]    mix_high;
  logic [tam_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         wr_en;

  logic v1;
  logic v2;
  logic v3;
  tam_pkg::pipe_ctrl_t ctrl;

  logic [tam_pkg::AXIS_W-1:0] axis_raw [tam_pkg::AXES];
  tam_pkg::shape_t            shaped   [tam_pkg::AXES];
  tam_pkg::thrust_t           thrust   [tam_pkg::THRUSTERS];

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[tam_pkg::APB_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= tam_pkg::CURVE_MODE_RST;
      mix_low    <= tam_pkg::MIX_LOW_RST;
      mix_high   <= tam_pkg::MIX_HIGH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tam_pkg::REG_CURVE_MODE: curve_mode <= pwdata[0];
        tam_pkg::REG_MIX_LOW:    mix_low    <= pwdata[tam_pkg::MIX_W-1:0];
        tam_pkg::REG_MIX_HIGH:   mix_high   <= pwdata[tam_pkg::MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tam_pkg::REG_CURVE_MODE: prdata = {{(tam_pkg::APB_DATA_W-1){1'b0}}, curve_mode};
      tam_pkg::REG_MIX_LOW:    prdata = tam_pkg::APB_DATA_W'(mix_low);
      tam_pkg::REG_MIX_HIGH:   prdata = tam_pkg::APB_DATA_W'(mix_high);
      default:                 prdata = '0;
    endcase
  end

  // pipe control: a stage loads when empty or when the next one loads
  always_comb begin
    ctrl.s3_en      = !v3 || demand.ready;
    ctrl.s2_en      = !v2 || ctrl.s3_en;
    ctrl.s1_en      = !v1 || ctrl.s2_en;
    ctrl.curve_mode = curve_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctrl.s1_en) begin
        v1 <= cmd.valid;
      end
      if (ctrl.s2_en) begin
        v2 <= v1;
      end
      if (ctrl.s3_en) begin
        v3 <= v2;
      end
    end
  end

  assign cmd.ready    = ctrl.s1_en;
  assign demand.valid = v3;

  assign axis_raw[0] = cmd.axis_x;
  assign axis_raw[1] = cmd.axis_y;
  assign axis_raw[2] = cmd.axis_z;
  assign axis_raw[3] = cmd.axis_yaw;
  assign axis_raw[4] = cmd.axis_roll;
  assign axis_raw[5] = cmd.axis_pitch;

  for (genvar a = 0; a < tam_pkg::AXES; a++) begin : g_axis
    tam_axis_shaper #(
      .INPUT_MID   (INPUT_MID),
      .LINEAR_GAIN (LINEAR_GAIN)
    ) u_shaper (
      .clk    (clk),
      .ctrl   (ctrl),
      .raw    (axis_raw[a]),
      .shaped (shaped[a])
    );
  end

  for (genvar t = 0; t < tam_pkg::THRUSTERS; t++) begin : g_thrust
    tam_pkg::coef_row_t row;
    if (t < tam_pkg::ROWS_REG) begin : g_low
      assign row = mix_low[t*tam_pkg::ROW_W +: tam_pkg::ROW_W];
    end else begin : g_high
      assign row = mix_high[(t-tam_pkg::ROWS_REG)*tam_pkg::ROW_W +: tam_pkg::ROW_W];
    end
    tam_thrust_mix u_mix (
      .clk    (clk),
      .ctrl   (ctrl),
      .coef   (row),
      .shaped (shaped),
      .thrust (thrust[t])
    );
  end

  assign demand.thrust_1 = thrust[0];
  assign demand.thrust_2 = thrust[1];
  assign demand.thrust_3 = thrust[2];
  assign demand.thrust_4 = thrust[3];
  assign demand.thrust_5 = thrust[4];
  assign demand.thrust_6 = thrust[5];
  assign demand.thrust_7 = thrust[6];
  assign demand.thrust_8 = thrust[7];

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> v1)
    else $error("accepted request did not enter stage one");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    v1 && !ctrl.s2_en |=> v1)
    else $error("stage one dropped a request while stalled");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    demand.valid && demand.ready && !v2 |=> !demand.valid)
    else $error("result repeated after delivery");

  a_stage2_moves: assert property (@(posedge clk) disable iff (rst)
    v2 && ctrl.s3_en |=> v3)
    else $error("stage two request lost on its way to the output");

endmodule

>>> sim/thruster_axis_mixer_test.sv
module thruster_axis_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MID          = 125;
  localparam int GAIN         = 100;
  localparam int SQ_DIV       = 10;
  localparam int SQ_TOP       = (MID * MID) / SQ_DIV;
  localparam int AXIS_TOP     = 250;
  localparam int AXIS_MAX     = 255;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTS   = 40;

  localparam logic CURVE_LINEAR = 1'b0;
  localparam logic CURVE_SQUARE = 1'b1;

  localparam logic [tam_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [tam_pkg::COEF_W-1:0] COEF_ZERO = 2'b00;
  localparam logic [tam_pkg::COEF_W-1:0] COEF_RSVD = 2'b10;
  localparam int COEFS_REG = tam_pkg::MIX_W / tam_pkg::COEF_W;
  localparam logic [tam_pkg::MIX_W-1:0] MIX_ALL_POS  = {COEFS_REG{tam_pkg::COEF_POS}};
  localparam logic [tam_pkg::MIX_W-1:0] MIX_ALL_NEG  = {COEFS_REG{tam_pkg::COEF_NEG}};
  localparam logic [tam_pkg::MIX_W-1:0] MIX_ALL_ZERO = {COEFS_REG{COEF_ZERO}};
  localparam logic [tam_pkg::MIX_W-1:0] MIX_ALL_RSVD = {COEFS_REG{COEF_RSVD}};

  // index 0 is x, then y, z, yaw, roll, pitch
  typedef logic [tam_pkg::AXES-1:0][tam_pkg::AXIS_W-1:0] axis_cmd_t;
  typedef tam_pkg::thrust_t [tam_pkg::THRUSTERS-1:0] demand_t;

  typedef struct {
    axis_cmd_t cmd;
    bit        typed;
    demand_t   want;
  } vector_row_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HOLD} stall_kind_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tam_pkg::APB_ADDR_W-1:0] paddr;
  logic [tam_pkg::APB_DATA_W-1:0] pwdata;
  logic [tam_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  tam_cmd_if    cmd_bus();
  tam_thrust_if demand_bus();

  thruster_axis_mixer #(
    .INPUT_MID   (MID),
    .LINEAR_GAIN (GAIN)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus),
    .demand  (demand_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's registers
  logic                     curve_sel;
  logic [tam_pkg::MIX_W-1:0] mix_lo;
  logic [tam_pkg::MIX_W-1:0] mix_hi;

  demand_t     pending_demands[$];
  vector_row_t vectors[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic int shape_axis_val(input logic [tam_pkg::AXIS_W-1:0] raw);
    int off;
    int mag;
    off = int'(raw) - MID;
    if (curve_sel == CURVE_LINEAR)
      return off * GAIN;
    mag = (off < 0) ? -off : off;
    return (off < 0) ? -((mag * mag) / SQ_DIV) : (mag * mag) / SQ_DIV;
  endfunction

  function automatic int mix_coef(input int t, input int a);
    logic [tam_pkg::MIX_W-1:0]  row_reg;
    logic [tam_pkg::COEF_W-1:0] code;
    row_reg = (t < tam_pkg::ROWS_REG) ? mix_lo : mix_hi;
    code = row_reg[(t % tam_pkg::ROWS_REG) * tam_pkg::ROW_W + a * tam_pkg::COEF_W
                   +: tam_pkg::COEF_W];
    if (code == tam_pkg::COEF_POS)
      return 1;
    if (code == tam_pkg::COEF_NEG)
      return -1;
    return 0;  // zero and the reserved code
  endfunction

  function automatic demand_t mix_demand(input axis_cmd_t c);
    int      shaped[tam_pkg::AXES];
    int      sum;
    demand_t d;
    for (int a = 0; a < tam_pkg::AXES; a++)
      shaped[a] = shape_axis_val(c[a]);
    for (int t = 0; t < tam_pkg::THRUSTERS; t++) begin
      sum = 0;
      for (int a = 0; a < tam_pkg::AXES; a++)
        sum += mix_coef(t, a) * shaped[a];
      if (sum > tam_pkg::SAT_MAX)
        sum = tam_pkg::SAT_MAX;
      if (sum < tam_pkg::SAT_MIN)
        sum = tam_pkg::SAT_MIN;
      d[t] = tam_pkg::thrust_t'(sum);
    end
    return d;
  endfunction

  function automatic axis_cmd_t rand_cmd();
    axis_cmd_t c;
    for (int a = 0; a < tam_pkg::AXES; a++) begin
      case ($urandom_range(0, 15))
        0: c[a] = '0;
        1: c[a] = tam_pkg::AXIS_W'(AXIS_TOP);
        2: c[a] = tam_pkg::AXIS_W'($urandom_range(AXIS_TOP + 1, AXIS_MAX));
        3: c[a] = tam_pkg::AXIS_W'(MID);
        default: c[a] = tam_pkg::AXIS_W'($urandom_range(0, AXIS_TOP));
      endcase
    end
    return c;
  endfunction

  function automatic logic [tam_pkg::MIX_W-1:0] rand_mix();
    logic [tam_pkg::APB_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    return w[tam_pkg::MIX_W-1:0];
  endfunction

  task automatic apb_write(input logic [tam_pkg::REG_IDX_W-1:0] idx,
                           input logic [tam_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tam_pkg::REG_CURVE_MODE: curve_sel = data[0];
      tam_pkg::REG_MIX_LOW:    mix_lo = data[tam_pkg::MIX_W-1:0];
      tam_pkg::REG_MIX_HIGH:   mix_hi = data[tam_pkg::MIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [tam_pkg::REG_IDX_W-1:0] idx,
                          output logic [tam_pkg::APB_DATA_W-1:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [tam_pkg::APB_DATA_W-1:0] rd;
    apb_read(tam_pkg::REG_CURVE_MODE, rd);
    if (rd[0] !== curve_sel)
      report_mismatch($sformatf("curve_mode reads %0b, wrote %0b", rd[0], curve_sel));
    apb_read(tam_pkg::REG_MIX_LOW, rd);
    if (rd[tam_pkg::MIX_W-1:0] !== mix_lo)
      report_mismatch($sformatf("mix_low reads %h, wrote %h",
                                rd[tam_pkg::MIX_W-1:0], mix_lo));
    apb_read(tam_pkg::REG_MIX_HIGH, rd);
    if (rd[tam_pkg::MIX_W-1:0] !== mix_hi)
      report_mismatch($sformatf("mix_high reads %h, wrote %h",
                                rd[tam_pkg::MIX_W-1:0], mix_hi));
  endtask

  // junk sets the bits above each register and pokes the unmapped slot
  task automatic apply_config(input logic curve, input logic [tam_pkg::MIX_W-1:0] lo,
                              input logic [tam_pkg::MIX_W-1:0] hi, input bit junk);
    logic [tam_pkg::APB_DATA_W-1:0] pad;
    pad = junk ? {$urandom, $urandom} : '0;
    apb_write(tam_pkg::REG_CURVE_MODE, {pad[tam_pkg::APB_DATA_W-1:1], curve});
    apb_write(tam_pkg::REG_MIX_LOW, {pad[tam_pkg::APB_DATA_W-1:tam_pkg::MIX_W], lo});
    apb_write(tam_pkg::REG_MIX_HIGH, {pad[tam_pkg::APB_DATA_W-1:tam_pkg::MIX_W], hi});
    if (junk)
      apb_write(REG_SPARE, {$urandom, $urandom});
    check_regs();
  endtask

  task automatic send_cmd(input axis_cmd_t c, input bit typed, input demand_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) cmd_bus.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    cmd_bus.valid      <= 1'b1;
    cmd_bus.axis_x     <= c[0];
    cmd_bus.axis_y     <= c[1];
    cmd_bus.axis_z     <= c[2];
    cmd_bus.axis_yaw   <= c[3];
    cmd_bus.axis_roll  <= c[4];
    cmd_bus.axis_pitch <= c[5];
    do @(posedge clk); while (!cmd_bus.ready);
    pending_demands.push_back(typed ? want : mix_demand(c));
    burst_left--;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_cmd(rand_cmd(), 1'b0, '0);
  endtask

  task automatic finish_phase();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_demands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : demand_check
    demand_t seen_demand;
    demand_t want_demand;
    if (!rst && demand_bus.valid && demand_bus.ready) begin
      seen_demand = {demand_bus.thrust_8, demand_bus.thrust_7, demand_bus.thrust_6,
                     demand_bus.thrust_5, demand_bus.thrust_4, demand_bus.thrust_3,
                     demand_bus.thrust_2, demand_bus.thrust_1};
      if (pending_demands.size() == 0) begin
        report_mismatch("thrust result with no request pending");
      end else begin
        want_demand = pending_demands.pop_front();
        for (int t = 0; t < tam_pkg::THRUSTERS; t++)
          if (seen_demand[t] !== want_demand[t])
            report_mismatch($sformatf("thrust_%0d got %0d expected %0d", t + 1,
                                      $signed(seen_demand[t]), $signed(want_demand[t])));
      end
    end
  end

  // receiver stalls; one long hold every dozen segments backs up the pipe
  initial begin : thrust_sink
    int          seg;
    int          len;
    int          tick;
    stall_kind_t kind;
    demand_bus.ready = 1'b0;
    seg  = 0;
    tick = 0;
    @(negedge clk);
    while (rst || !cmd_bus.valid) @(negedge clk);
    forever begin
      kind = stall_kind_t'($urandom_range(0, 2));
      len  = $urandom_range(8, 60);
      if (seg % 12 == 2) begin
        kind = STALL_HOLD;
        len  = HOLD_CYCLES;
      end
      repeat (len) begin
        case (kind)
          STALL_NONE:    demand_bus.ready <= 1'b1;
          STALL_RANDOM:  demand_bus.ready <= 1'($urandom_range(0, 1));
          STALL_PATTERN: demand_bus.ready <= (tick % 3 != 0);
          default:       demand_bus.ready <= 1'b0;
        endcase
        tick++;
        @(negedge clk);
      end
      seg++;
    end
  end

  initial begin : stimulus
    axis_cmd_t c;
    demand_t   all_top;
    demand_t   all_zero;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.axis_x     = '0;
    cmd_bus.axis_y     = '0;
    cmd_bus.axis_z     = '0;
    cmd_bus.axis_yaw   = '0;
    cmd_bus.axis_roll  = '0;
    cmd_bus.axis_pitch = '0;
    curve_sel = tam_pkg::CURVE_MODE_RST;
    mix_lo    = tam_pkg::MIX_LOW_RST;
    mix_hi    = tam_pkg::MIX_HIGH_RST;

    // reset mixing: t1 = x+y+yaw, t2 = x-y-yaw, t3 = y-x-yaw, t4 = yaw-x-y,
    // t5..t8 = z
    all_top  = {{4{tam_pkg::thrust_t'(SQ_TOP)}}, {3{tam_pkg::thrust_t'(-SQ_TOP)}},
                tam_pkg::thrust_t'(3 * SQ_TOP)};
    all_zero = {{4{tam_pkg::thrust_t'(-SQ_TOP)}}, {3{tam_pkg::thrust_t'(SQ_TOP)}},
                tam_pkg::thrust_t'(-3 * SQ_TOP)};

    vectors.push_back('{cmd: {tam_pkg::AXES{tam_pkg::AXIS_W'(MID)}}, typed: 1'b1,
                        want: '0});
    vectors.push_back('{cmd: {tam_pkg::AXES{tam_pkg::AXIS_W'(AXIS_TOP)}}, typed: 1'b1,
                        want: all_top});
    vectors.push_back('{cmd: {tam_pkg::AXES{tam_pkg::AXIS_W'(0)}}, typed: 1'b1,
                        want: all_zero});
    vectors.push_back('{cmd: {tam_pkg::AXES{tam_pkg::AXIS_W'(AXIS_MAX)}}, typed: 1'b0,
                        want: '0});
    vectors.push_back('{cmd: {tam_pkg::AXES{tam_pkg::AXIS_W'(AXIS_TOP + 1)}}, typed: 1'b0,
                        want: '0});
    for (int a = 0; a < tam_pkg::AXES; a++) begin
      c = {tam_pkg::AXES{tam_pkg::AXIS_W'(MID)}};
      c[a] = tam_pkg::AXIS_W'(AXIS_TOP);
      vectors.push_back('{cmd: c, typed: 1'b0, want: '0});
      c[a] = '0;
      vectors.push_back('{cmd: c, typed: 1'b0, want: '0});
    end
    vectors.push_back('{cmd: {tam_pkg::AXES{tam_pkg::AXIS_W'(MID - 1)}}, typed: 1'b0,
                        want: '0});
    vectors.push_back('{cmd: {tam_pkg::AXES{tam_pkg::AXIS_W'(MID + 1)}}, typed: 1'b0,
                        want: '0});
    vectors.push_back('{cmd: {3{tam_pkg::AXIS_W'(0), tam_pkg::AXIS_W'(AXIS_MAX)}},
                        typed: 1'b0, want: '0});
    vectors.push_back('{cmd: {3{tam_pkg::AXIS_W'(AXIS_MAX), tam_pkg::AXIS_W'(0)}},
                        typed: 1'b0, want: '0});
    vectors.push_back('{cmd: {3{tam_pkg::AXIS_W'(MID + 10), tam_pkg::AXIS_W'(MID - 10)}},
                        typed: 1'b0, want: '0});

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset values, directed table, then random traffic on each setting
    check_regs();
    foreach (vectors[i])
      send_cmd(vectors[i].cmd, vectors[i].typed, vectors[i].want);
    send_random(70);
    finish_phase();

    apply_config(CURVE_LINEAR, tam_pkg::MIX_LOW_RST, tam_pkg::MIX_HIGH_RST, 1'b0);
    send_random(80);
    finish_phase();

    apply_config(CURVE_SQUARE, MIX_ALL_POS, MIX_ALL_POS, 1'b0);
    send_random(70);
    finish_phase();

    apply_config(CURVE_LINEAR, MIX_ALL_NEG, MIX_ALL_NEG, 1'b1);
    send_random(70);
    finish_phase();

    apply_config(CURVE_SQUARE, MIX_ALL_ZERO, MIX_ALL_ZERO, 1'b1);
    send_random(50);
    finish_phase();

    apply_config(CURVE_LINEAR, MIX_ALL_RSVD, rand_mix(), 1'b1);
    send_random(70);
    finish_phase();

    apply_config(CURVE_SQUARE, rand_mix(), rand_mix(), 1'b0);
    send_random(70);
    finish_phase();

    apply_config(CURVE_LINEAR, rand_mix(), rand_mix(), 1'b1);
    send_random(70);
    finish_phase();

    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
